FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LBD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define LBD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define LBD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LBD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/lbd_pkg.sv
// ----------------------------------------------------------------------------
// lbd_pkg
// Shared types, codes and constants of the LED blink and dim controller.
// ----------------------------------------------------------------------------
package lbd_pkg;

  localparam int NumLeds  = 4;
  localparam int LedIdxW  = (NumLeds > 1) ? $clog2(NumLeds) : 1;
  localparam int TicksW   = 13;
  localparam int LogStart = 74;
  localparam int MaxOut   = 4;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_DIM   = 2'd1,
    REQ_BLINK = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_DISABLED = 2'd1,
    STAT_BAD_ARG  = 2'd2
  } status_t;

  typedef enum logic {
    CFG_LEDS_DISABLED = 1'b0,
    CFG_FOREVER_CODE  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_TICK,
    FSM_TICK_END,
    FSM_DIV_PER,
    FSM_DIV_OFF,
    FSM_BLINK_WR
  } fsm_t;

  typedef struct packed {
    logic [1:0] led;
    logic [9:0] duty;
    logic       level;
    logic       upd;
    status_t    status;
    logic       last;
  } res_t;

  // Upper part of the logarithmic brightness curve, percent 74 to 100.
  function automatic logic [9:0] log_duty(input logic [4:0] k);
    logic [9:0] d;
    case (k)
      5'd0:    d = 10'd75;
      5'd1:    d = 10'd83;
      5'd2:    d = 10'd92;
      5'd3:    d = 10'd102;
      5'd4:    d = 10'd112;
      5'd5:    d = 10'd124;
      5'd6:    d = 10'd137;
      5'd7:    d = 10'd152;
      5'd8:    d = 10'd167;
      5'd9:    d = 10'd185;
      5'd10:   d = 10'd205;
      5'd11:   d = 10'd226;
      5'd12:   d = 10'd250;
      5'd13:   d = 10'd276;
      5'd14:   d = 10'd305;
      5'd15:   d = 10'd337;
      5'd16:   d = 10'd373;
      5'd17:   d = 10'd412;
      5'd18:   d = 10'd455;
      5'd19:   d = 10'd503;
      5'd20:   d = 10'd556;
      5'd21:   d = 10'd615;
      5'd22:   d = 10'd679;
      5'd23:   d = 10'd751;
      5'd24:   d = 10'd830;
      5'd25:   d = 10'd917;
      default: d = 10'd1000;
    endcase
    return d;
  endfunction

endpackage

FILE: hw/rtl/led_blink_dim_controller_unit.sv
// ----------------------------------------------------------------------------
// led_blink_dim_controller_unit
// Per-LED blink and dimming controller with a tick-driven countdown walk.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Request types are a
// 10 ms tick, set_dim and set_blink; the unused type is dropped silently.
// Results leave on the out_ ports for exactly one cycle each, marked by
// out_valid; out_last marks the final result of a request. The receiver
// cannot hold results off, so nothing ever backs up into the block.
// set_dim and every rejected request are answered straight from idle: the result shows
// in the cycle after the request and busy never rises.
// set_blink runs the period and then the off time through one shared
// divide-by-ten unit; busy stays high through DIV_PER, DIV_OFF and
// BLINK_WR, and the result shows in the cycle in which busy falls.
// A tick visits one LED per cycle in FSM_TICK, then passes FSM_TICK_END,
// holds busy throughout and gives up to four results, at most one per cycle.
// Configuration goes through the APB port at any idle time; pready is tied
// high. Synchronous reset clears all LED state and sets forever_code to 255.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module led_blink_dim_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [1:0]  in_led_sel,
  input  logic signed [7:0] in_percent,
  input  logic [15:0] in_period_ms,
  input  logic [15:0] in_off_time_ms,
  input  logic [7:0]  in_pulse_count,
  output logic        out_valid,
  output logic [1:0]  out_led_index_out,
  output logic [9:0]  out_duty,
  output logic        out_level_on,
  output logic        out_drive_update,
  output logic [1:0]  out_status,
  output logic        out_last
);

  localparam int IdxW = lbd_pkg::LedIdxW;
  localparam int TW   = lbd_pkg::TicksW;

  // Configuration registers
  logic       disabled_r;
  logic [7:0] forever_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disabled_r <= 1'b0;
      forever_r  <= 8'd255;
    end else if (cfg_wr) begin
      unique case (lbd_pkg::cfg_reg_t'(paddr[2]))
        lbd_pkg::CFG_LEDS_DISABLED: disabled_r <= pwdata[0];
        lbd_pkg::CFG_FOREVER_CODE:  forever_r  <= pwdata[7:0];
        default:                    disabled_r <= disabled_r;
      endcase
    end
  end

  always_comb begin
    unique case (lbd_pkg::cfg_reg_t'(paddr[2]))
      lbd_pkg::CFG_LEDS_DISABLED: prdata = {31'd0, disabled_r};
      lbd_pkg::CFG_FOREVER_CODE:  prdata = {24'd0, forever_r};
      default:                    prdata = 32'd0;
    endcase
  end

  // Per-LED state
  logic [TW-1:0]    cd_r   [lbd_pkg::NumLeds];
  logic [TW-1:0]    per_r  [lbd_pkg::NumLeds];
  logic [TW-1:0]    off_r  [lbd_pkg::NumLeds];
  logic [7:0]       pl_r   [lbd_pkg::NumLeds];
  logic signed [7:0] dim_r [lbd_pkg::NumLeds];

  // Sequencer registers
  lbd_pkg::fsm_t    state_r, state_nxt;
  logic [IdxW-1:0]  idx_r, idx_nxt;
  logic [2:0]       n_r, n_nxt;
  logic             pend_v_r, pend_v_nxt;
  lbd_pkg::res_t    pend_r, pend_nxt;
  lbd_pkg::res_t    res_r, res_nxt;
  logic             out_v_r, out_v_nxt;
  logic [1:0]       bled_r, bled_nxt;
  logic [15:0]      boff_r, boff_nxt;
  logic [7:0]       bpl_r, bpl_nxt;
  logic [TW-1:0]    bper_r, bper_nxt;

  // Divider interface
  logic             div_start;
  logic [15:0]      div_in;
  logic             div_done;
  logic [TW-1:0]    div_q;

  lbd_div10 u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_in),
    .done     (div_done),
    .quotient (div_q)
  );

  // Shared percent-to-drive mapping
  logic signed [7:0] drv_pct;
  logic [9:0]        drv_duty;
  logic              drv_level;

  lbd_drive u_drive (
    .pct   (drv_pct),
    .duty  (drv_duty),
    .level (drv_level)
  );

  // Selected LED for set requests
  logic [7:0]       sel_w;
  logic [IdxW-1:0]  sel_ix;
  logic             sel_ok;
  logic [7:0]       bled_w;
  logic [IdxW-1:0]  bled_ix;
  logic [7:0]       idx_w;

  assign sel_w   = 8'(in_led_sel);
  assign sel_ix  = sel_w[IdxW-1:0];
  assign sel_ok  = sel_w < 8'(lbd_pkg::NumLeds);
  assign bled_w  = 8'(bled_r);
  assign bled_ix = bled_w[IdxW-1:0];
  assign idx_w   = 8'(idx_r);

  // Countdown step for the LED under the walk pointer
  logic [TW-1:0] cd_cur, cd_dec, cd_new;
  logic [7:0]    pl_cur, pl_new;
  logic          t_active, t_expire, t_dead, t_drive;
  logic signed [7:0] t_pct;

  always_comb begin
    cd_cur   = cd_r[idx_r];
    pl_cur   = pl_r[idx_r];
    cd_dec   = cd_cur - TW'(1);
    t_active = (cd_cur != '0);
    t_expire = t_active && (cd_dec == '0);
    t_dead   = t_expire && (pl_cur == 8'd0);
    pl_new   = (pl_cur != forever_r) ? pl_cur - 8'd1 : pl_cur;
    cd_new   = cd_dec;
    if (t_expire && !t_dead && (pl_new != 8'd0)) begin
      cd_new = per_r[idx_r];
    end
    t_drive  = t_active && !t_dead;
    // The LED is dark for the last off-time ticks of each period.
    t_pct    = (cd_new <= off_r[idx_r]) ? 8'sd0 : dim_r[idx_r];
  end

  // Sequencer
  logic accept;
  logic is_tick, is_dim, is_blink;

  assign accept   = start && !busy;
  assign is_tick  = (lbd_pkg::req_t'(in_req_type) == lbd_pkg::REQ_TICK);
  assign is_dim   = (lbd_pkg::req_t'(in_req_type) == lbd_pkg::REQ_DIM);
  assign is_blink = (lbd_pkg::req_t'(in_req_type) == lbd_pkg::REQ_BLINK);

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    n_nxt      = n_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    res_nxt    = res_r;
    out_v_nxt  = 1'b0;
    bled_nxt   = bled_r;
    boff_nxt   = boff_r;
    bpl_nxt    = bpl_r;
    bper_nxt   = bper_r;
    div_start  = 1'b0;
    div_in     = in_period_ms;
    drv_pct    = in_percent;

    unique case (state_r)
      lbd_pkg::FSM_IDLE: begin
        res_nxt.led    = in_led_sel;
        res_nxt.duty   = 10'd0;
        res_nxt.level  = 1'b0;
        res_nxt.upd    = 1'b0;
        res_nxt.status = lbd_pkg::STAT_OK;
        res_nxt.last   = 1'b1;
        if (accept) begin
          if (is_tick) begin
            idx_nxt    = '0;
            n_nxt      = 3'd0;
            pend_v_nxt = 1'b0;
            state_nxt  = lbd_pkg::FSM_TICK;
          end else if (is_dim || is_blink) begin
            out_v_nxt = 1'b1;
            if (disabled_r) begin
              res_nxt.status = lbd_pkg::STAT_DISABLED;
            end else if (!sel_ok) begin
              res_nxt.status = lbd_pkg::STAT_BAD_ARG;
            end else if (is_dim) begin
              if (in_percent > 8'sd100) begin
                res_nxt.status = lbd_pkg::STAT_BAD_ARG;
              end else begin
                res_nxt.duty  = drv_duty;
                res_nxt.level = drv_level;
                res_nxt.upd   = 1'b1;
              end
            end else if (in_off_time_ms > in_period_ms) begin
              res_nxt.status = lbd_pkg::STAT_BAD_ARG;
            end else begin
              // Result waits until both divisions are done.
              out_v_nxt = 1'b0;
              bled_nxt  = in_led_sel;
              boff_nxt  = in_off_time_ms;
              bpl_nxt   = in_pulse_count;
              div_start = 1'b1;
              state_nxt = lbd_pkg::FSM_DIV_PER;
            end
          end
        end
      end

      lbd_pkg::FSM_TICK: begin
        drv_pct = t_pct;
        if (t_drive && (n_r < 3'(lbd_pkg::MaxOut))) begin
          if (pend_v_r) begin
            res_nxt   = pend_r;
            out_v_nxt = 1'b1;
          end
          pend_v_nxt      = 1'b1;
          pend_nxt.led    = idx_w[1:0];
          pend_nxt.duty   = drv_duty;
          pend_nxt.level  = drv_level;
          pend_nxt.upd    = 1'b1;
          pend_nxt.status = lbd_pkg::STAT_OK;
          pend_nxt.last   = 1'b0;
          n_nxt           = n_r + 3'd1;
        end
        if (idx_r == IdxW'(lbd_pkg::NumLeds - 1)) begin
          state_nxt = lbd_pkg::FSM_TICK_END;
        end else begin
          idx_nxt = idx_r + IdxW'(1);
        end
      end

      lbd_pkg::FSM_TICK_END: begin
        if (pend_v_r) begin
          res_nxt      = pend_r;
          res_nxt.last = 1'b1;
          out_v_nxt    = 1'b1;
        end
        pend_v_nxt = 1'b0;
        state_nxt  = lbd_pkg::FSM_IDLE;
      end

      lbd_pkg::FSM_DIV_PER: begin
        div_in = boff_r;
        if (div_done) begin
          bper_nxt  = div_q;
          div_start = 1'b1;
          state_nxt = lbd_pkg::FSM_DIV_OFF;
        end
      end

      lbd_pkg::FSM_DIV_OFF: begin
        div_in = boff_r;
        if (div_done) begin
          state_nxt = lbd_pkg::FSM_BLINK_WR;
        end
      end

      lbd_pkg::FSM_BLINK_WR: begin
        res_nxt.led    = bled_r;
        res_nxt.duty   = 10'd0;
        res_nxt.level  = 1'b0;
        res_nxt.upd    = 1'b0;
        res_nxt.status = lbd_pkg::STAT_OK;
        res_nxt.last   = 1'b1;
        out_v_nxt      = 1'b1;
        state_nxt      = lbd_pkg::FSM_IDLE;
      end

      default: state_nxt = lbd_pkg::FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= lbd_pkg::FSM_IDLE;
      idx_r    <= '0;
      n_r      <= 3'd0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      n_r      <= n_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    pend_r <= pend_nxt;
    res_r  <= res_nxt;
    bled_r <= bled_nxt;
    boff_r <= boff_nxt;
    bpl_r  <= bpl_nxt;
    bper_r <= bper_nxt;
  end

  // LED state updates
  logic dim_wr;

  assign dim_wr = (state_r == lbd_pkg::FSM_IDLE) && accept && is_dim && !disabled_r
                  && sel_ok && (in_percent <= 8'sd100);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lbd_pkg::NumLeds; i++) begin
        cd_r[i]  <= '0;
        per_r[i] <= '0;
        off_r[i] <= '0;
        pl_r[i]  <= 8'd0;
        dim_r[i] <= 8'sd0;
      end
    end else begin
      if (dim_wr) begin
        cd_r[sel_ix]  <= '0;
        dim_r[sel_ix] <= in_percent;
      end
      if (state_r == lbd_pkg::FSM_TICK) begin
        if (t_active) begin
          cd_r[idx_r] <= cd_new;
        end
        if (t_expire && !t_dead) begin
          pl_r[idx_r] <= pl_new;
        end
      end
      if (state_r == lbd_pkg::FSM_BLINK_WR) begin
        off_r[bled_ix] <= div_q;
        per_r[bled_ix] <= bper_r;
        cd_r[bled_ix]  <= bper_r;
        pl_r[bled_ix]  <= bpl_r;
      end
    end
  end

  assign busy              = (state_r != lbd_pkg::FSM_IDLE);
  assign out_valid         = out_v_r;
  assign out_led_index_out = res_r.led;
  assign out_duty          = res_r.duty;
  assign out_level_on      = res_r.level;
  assign out_drive_update  = res_r.upd;
  assign out_status        = res_r.status;
  assign out_last          = res_r.last;

  `LBD_ASSERT_IMP(a_err_is_last, clk, rst_n, out_valid && (out_status != lbd_pkg::STAT_OK), out_last && !out_drive_update)
  `LBD_ASSERT_IMP(a_more_follow_busy, clk, rst_n, out_valid && !out_last, busy)
  `LBD_ASSERT_IMP(a_tick_cap, clk, rst_n, busy, n_r <= 3'(lbd_pkg::MaxOut))
  `LBD_ASSERT_IMP(a_div_idle, clk, rst_n, state_r == lbd_pkg::FSM_IDLE, !div_done)

endmodule

FILE: hw/rtl/lbd_div10.sv
// ----------------------------------------------------------------------------
// lbd_div10
// Divide-by-ten unit: a reciprocal multiply whose quotient is registered and
// flagged by done in the cycle after start.
// ----------------------------------------------------------------------------
module lbd_div10 (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [15:0]                 dividend,
  output logic                        done,
  output logic [lbd_pkg::TicksW-1:0]  quotient
);

  logic [31:0]                 prod;
  logic [lbd_pkg::TicksW-1:0]  q_r, q_nxt;
  logic                        done_r;

  always_comb begin
    // 52429 / 2^19 sits just above 1/10; over the whole 16-bit range the
    // error stays well below one quotient step, so the result is exact.
    prod  = {16'd0, dividend} * 32'd52429;
    q_nxt = start ? prod[19 +: lbd_pkg::TicksW] : q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start;
    end
    q_r <= q_nxt;
  end

  // 65535 / 10 fits in the tick width.
  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: hw/rtl/lbd_drive.sv
// ----------------------------------------------------------------------------
// lbd_drive
// Maps a signed brightness percentage to a PWM duty and a digital level.
// ----------------------------------------------------------------------------
module lbd_drive (
  input  logic signed [7:0] pct,
  output logic [9:0]        duty,
  output logic              level
);

  logic signed [7:0] clamped;
  logic [6:0]        ofs;

  always_comb begin
    clamped = (pct > 8'sd100) ? 8'sd100 : pct;
    ofs     = 7'(clamped - 8'sd74);
    if (pct <= 8'sd0) begin
      duty = 10'd0;
    end else if (clamped < 8'(lbd_pkg::LogStart)) begin
      duty = 10'(clamped);
    end else begin
      duty = lbd_pkg::log_duty(ofs[4:0]);
    end
    level = (pct >= 8'sd50);
  end

endmodule
